FILE: rtl/pba_pkg.sv
`timescale 1ns / 1ps
package pba_pkg;

	localparam int MAX_ORDER = 3;
	localparam int MAX_TERMS = 20;
	localparam int TERM_W    = 5;
	localparam int ORD_W     = 2;
	localparam int SIZE_W    = 11;
	localparam int CRD_W     = 10;
	localparam int ACC_W     = 54;

	localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

	// Shared divider: 48-bit dividend, 32-bit divisor, one quotient bit per cycle
	localparam int DIV_NW    = 48;
	localparam int DIV_DW    = 32;
	localparam int DIV_CNT_W = 6;

	localparam logic [2:0] REG_MAX_DEG    = 3'd0;
	localparam logic [2:0] REG_APPLY_MODE = 3'd1;
	localparam logic [2:0] REG_SIZE_X     = 3'd2;
	localparam logic [2:0] REG_SIZE_Y     = 3'd3;
	localparam logic [2:0] REG_SIZE_Z     = 3'd4;

	localparam logic [2:0] MODE_SUB  = 3'd0;
	localparam logic [2:0] MODE_ADD  = 3'd1;
	localparam logic [2:0] MODE_MUL  = 3'd2;
	localparam logic [2:0] MODE_DIV  = 3'd3;
	localparam logic [2:0] MODE_POLY = 3'd4;

	localparam logic OP_VOXEL = 1'b0;
	localparam logic OP_LOAD  = 1'b1;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_SAT  = 2'd1;
	localparam logic [1:0] STATUS_DIV0 = 2'd2;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_NORM_GO,
		S_NORM_WAIT,
		S_TERM_INIT,
		S_FACT_GO,
		S_FACT_WAIT,
		S_COEF_WAIT,
		S_APPLY,
		S_COMB,
		S_MULT_WAIT,
		S_DIV_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic               sat;
		logic signed [31:0] val;
	} sat_t;

	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		if (v > 64'sd2147483647) begin
			r.sat = 1'b1;
			r.val = 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r.sat = 1'b1;
			r.val = 32'sh8000_0000;
		end else begin
			r.sat = 1'b0;
			r.val = v[31:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/pba_mul.sv
`timescale 1ns / 1ps
module pba_mul (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] prod_q
);

	// Registered 32x32 signed product
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

FILE: rtl/pba_div.sv
`timescale 1ns / 1ps
module pba_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pba_pkg::div_req_t req,
	output pba_pkg::div_rsp_t rsp
);

	logic                              busy_q;
	logic                              done_q;
	logic [pba_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [pba_pkg::DIV_NW-1:0]        num_q;
	logic [pba_pkg::DIV_DW-1:0]        rem_q;
	logic [pba_pkg::DIV_DW-1:0]        den_q;
	logic [pba_pkg::DIV_DW:0]          shifted;
	logic [pba_pkg::DIV_DW+1:0]        diff;
	logic                              ge;

	// Restoring division: shift one dividend bit into the remainder per cycle
	assign shifted = {rem_q, num_q[pba_pkg::DIV_NW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	assign ge      = ~diff[pba_pkg::DIV_DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pba_pkg::DIV_CNT_W'(pba_pkg::DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[pba_pkg::DIV_NW-2:0], ge};
			rem_q <= ge ? diff[pba_pkg::DIV_DW-1:0] : shifted[pba_pkg::DIV_DW-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = num_q;

endmodule

FILE: rtl/poly_background_apply.sv
`timescale 1ns / 1ps
// Voxel stream background correction with a 3D polynomial of total degree up
// to three (up to twenty terms, ordered x outer, z inner).
// Input channel (in_valid / in_stall): each beat is either a coefficient load
// (op = 1), written into the term table with no result, or a
// voxel (op = 0), which yields exactly one result beat on the output channel
// (out_valid / out_stall) carrying corrected_value and status.
// A voxel runs on one shared 48-step divider and one shared registered
// multiplier under the sequencer: three coordinate normalizations on the
// divider, then per term one multiply per exponent factor and one for the
// coefficient, then a combine step (plus a multiply in multiply mode, or a
// divide by a nonzero polynomial in divide mode). in_stall is high for the whole voxel.
// The result lands in an output register; the block takes the next beat while
// it waits, and only stalls a second voxel from finishing until it drains.
// Reset clears the coefficient table to zero, sets the maximum degree to 1,
// apply_mode to subtract and all sizes to 256, and empties the output register.
// Registers sit on the APB port at byte addresses 0,4,8,12,16; write them
// only while the block is idle.
module poly_background_apply (
	input  logic               clk,
	input  logic               arst_n,
	// APB configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// input beat
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [9:0]         coord_x,
	input  logic [9:0]         coord_y,
	input  logic [9:0]         coord_z,
	input  logic signed [31:0] voxel_value,
	input  logic [4:0]         term_index,
	input  logic signed [31:0] term_coefficient,
	// result beat
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] corrected_value,
	output logic [1:0]         status
);

	localparam int SW = pba_pkg::SIZE_W;
	localparam int CW = pba_pkg::CRD_W;
	localparam int AW = pba_pkg::ACC_W;

	// configuration
	logic [pba_pkg::ORD_W-1:0] deg_max_q;
	logic [2:0]                apply_mode_q;
	logic [SW-1:0]             size_x_q, size_y_q, size_z_q;
	logic                      cfg_wr;
	logic [2:0]                cfg_idx;

	// coefficient table
	logic signed [31:0] coef_q [pba_pkg::MAX_TERMS];

	// sequencer and datapath
	pba_pkg::state_t          state_q, state_d;
	logic [1:0]               axis_q;
	logic [CW-1:0]            cx_q, cy_q, cz_q;
	logic signed [31:0]       nx_q, ny_q, nz_q;
	logic signed [31:0]       v_q;
	logic [1:0]               a_q, b_q, c_q;
	logic [1:0]               ex_q, ey_q, ez_q;
	logic [pba_pkg::TERM_W-1:0] pos_q;
	logic signed [31:0]       m_q;
	logic signed [AW-1:0]     acc_q;
	logic signed [31:0]       p_q;
	logic signed [31:0]       res_q;
	logic                     sat_q;
	logic                     div0_q;
	logic                     neg_q;

	logic                     out_valid_q;
	logic signed [31:0]       out_val_q;
	logic [1:0]               out_stat_q;

	logic                     in_acc;
	logic                     out_free;

	// shared units
	logic signed [31:0]       mul_a, mul_b;
	logic signed [63:0]       prod_q;
	pba_pkg::div_req_t        div_req;
	pba_pkg::div_rsp_t        div_rsp;

	// normalization operands
	logic [CW-1:0]            crd_sel;
	logic [SW-1:0]            size_sel, size_eff;
	logic signed [SW:0]       crd_off;
	logic [SW-1:0]            dist_mag;
	logic signed [31:0]       norm_val;

	// term stepping
	logic [3:0]               sum_c, sum_b, sum_a;
	logic                     last_term;
	logic signed [31:0]       coef_rd;
	logic                     fact_x, fact_y, fact_z;

	// arithmetic results
	pba_pkg::sat_t            m_sat, p_sat, as_sat, mul_sat, div_sat;
	logic signed [63:0]       div_signed;
	logic [2:0]               mode_eff;

	pba_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	pba_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_stall  = (state_q != pba_pkg::S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign corrected_value = out_val_q;
	assign status    = out_stat_q;

	// ---------------------------------------------------------------- APB
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		case (cfg_idx)
			pba_pkg::REG_MAX_DEG:    prdata = {30'd0, deg_max_q};
			pba_pkg::REG_APPLY_MODE: prdata = {29'd0, apply_mode_q};
			pba_pkg::REG_SIZE_X:     prdata = {21'd0, size_x_q};
			pba_pkg::REG_SIZE_Y:     prdata = {21'd0, size_y_q};
			pba_pkg::REG_SIZE_Z:     prdata = {21'd0, size_z_q};
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_max_q    <= 2'd1;
			apply_mode_q <= pba_pkg::MODE_SUB;
			size_x_q     <= 11'd256;
			size_y_q     <= 11'd256;
			size_z_q     <= 11'd256;
		end else if (cfg_wr) begin
			case (cfg_idx)
				pba_pkg::REG_MAX_DEG:    deg_max_q    <= pwdata[1:0];
				pba_pkg::REG_APPLY_MODE: apply_mode_q <= pwdata[2:0];
				pba_pkg::REG_SIZE_X:     size_x_q     <= pwdata[SW-1:0];
				pba_pkg::REG_SIZE_Y:     size_y_q     <= pwdata[SW-1:0];
				pba_pkg::REG_SIZE_Z:     size_z_q     <= pwdata[SW-1:0];
				default: ;
			endcase
		end
	end

	// Coefficient loads; indexes past the table are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pba_pkg::MAX_TERMS; i++) coef_q[i] <= '0;
		end else if (in_acc && op == pba_pkg::OP_LOAD &&
			term_index < pba_pkg::TERM_W'(pba_pkg::MAX_TERMS)) begin
			coef_q[term_index] <= term_coefficient;
		end
	end

	// ---------------------------------------------------- combinational prep
	always_comb begin
		case (axis_q)
			pba_pkg::AXIS_X: begin crd_sel = cx_q; size_sel = size_x_q; end
			pba_pkg::AXIS_Y: begin crd_sel = cy_q; size_sel = size_y_q; end
			default:         begin crd_sel = cz_q; size_sel = size_z_q; end
		endcase
	end

	// Zero size counts as one; center is floor(size/2)
	assign size_eff = (size_sel == '0) ? SW'(1) : size_sel;
	assign crd_off  = $signed({2'b00, crd_sel}) - $signed({2'b00, size_eff[SW-1:1]});
	assign dist_mag = crd_off[SW] ? SW'(-crd_off) : crd_off[SW-1:0];
	assign norm_val = neg_q ? -$signed(div_rsp.quo[31:0]) : $signed(div_rsp.quo[31:0]);

	// Next exponent triple with a+b+c <= order, c innermost
	assign sum_c = 4'(a_q) + 4'(b_q) + 4'(c_q) + 4'd1;
	assign sum_b = 4'(a_q) + 4'(b_q) + 4'd1;
	assign sum_a = 4'(a_q) + 4'd1;
	assign last_term = (sum_a > 4'(deg_max_q)) && (sum_b > 4'(deg_max_q)) &&
		(sum_c > 4'(deg_max_q));

	assign coef_rd = (pos_q < pba_pkg::TERM_W'(pba_pkg::MAX_TERMS)) ?
		coef_q[pos_q] : 32'sd0;

	assign fact_x = (ex_q != 2'd0);
	assign fact_y = !fact_x && (ey_q != 2'd0);
	assign fact_z = !fact_x && !fact_y && (ez_q != 2'd0);

	always_comb begin
		case (apply_mode_q) inside
			pba_pkg::MODE_SUB, pba_pkg::MODE_ADD, pba_pkg::MODE_MUL,
			pba_pkg::MODE_DIV: mode_eff = apply_mode_q;
			default:           mode_eff = pba_pkg::MODE_POLY;
		endcase
	end

	assign m_sat   = pba_pkg::sat32(prod_q >>> 16);
	assign p_sat   = pba_pkg::sat32(64'(acc_q));
	assign as_sat  = (mode_eff == pba_pkg::MODE_SUB) ?
		pba_pkg::sat32(64'(v_q) - 64'(p_q)) : pba_pkg::sat32(64'(v_q) + 64'(p_q));
	assign mul_sat = pba_pkg::sat32(prod_q >>> 16);
	assign div_signed = neg_q ? -$signed({16'd0, div_rsp.quo}) : $signed({16'd0, div_rsp.quo});
	assign div_sat = pba_pkg::sat32(div_signed);

	// ---------------------------------------------------------- next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pba_pkg::S_IDLE:
				if (in_acc && op == pba_pkg::OP_VOXEL) state_d = pba_pkg::S_NORM_GO;
			pba_pkg::S_NORM_GO:   state_d = pba_pkg::S_NORM_WAIT;
			pba_pkg::S_NORM_WAIT:
				if (div_rsp.done)
					state_d = (axis_q == pba_pkg::AXIS_Z) ? pba_pkg::S_TERM_INIT
						: pba_pkg::S_NORM_GO;
			pba_pkg::S_TERM_INIT: state_d = pba_pkg::S_FACT_GO;
			pba_pkg::S_FACT_GO:
				state_d = (fact_x || fact_y || fact_z) ? pba_pkg::S_FACT_WAIT
					: pba_pkg::S_COEF_WAIT;
			pba_pkg::S_FACT_WAIT: state_d = pba_pkg::S_FACT_GO;
			pba_pkg::S_COEF_WAIT:
				state_d = last_term ? pba_pkg::S_APPLY : pba_pkg::S_TERM_INIT;
			pba_pkg::S_APPLY:     state_d = pba_pkg::S_COMB;
			pba_pkg::S_COMB: begin
				case (mode_eff)
					pba_pkg::MODE_MUL: state_d = pba_pkg::S_MULT_WAIT;
					pba_pkg::MODE_DIV:
						state_d = (p_q == 32'sd0) ? pba_pkg::S_DONE : pba_pkg::S_DIV_WAIT;
					default:           state_d = pba_pkg::S_DONE;
				endcase
			end
			pba_pkg::S_MULT_WAIT: state_d = pba_pkg::S_DONE;
			pba_pkg::S_DIV_WAIT:
				if (div_rsp.done) state_d = pba_pkg::S_DONE;
			pba_pkg::S_DONE:
				if (out_free) state_d = pba_pkg::S_IDLE;
			default:              state_d = pba_pkg::S_IDLE;
		endcase
	end

	// ------------------------------------------------- shared unit operands
	always_comb begin
		mul_a       = m_q;
		mul_b       = nx_q;
		div_req     = '0;
		div_req.num = pba_pkg::DIV_NW'({dist_mag, 16'd0});
		div_req.den = pba_pkg::DIV_DW'(size_eff);
		case (state_q)
			pba_pkg::S_NORM_GO: div_req.start = 1'b1;
			pba_pkg::S_FACT_GO: begin
				if (fact_x)      mul_b = nx_q;
				else if (fact_y) mul_b = ny_q;
				else if (fact_z) mul_b = nz_q;
				else begin
					mul_a = coef_rd;
					mul_b = m_q;
				end
			end
			pba_pkg::S_COMB: begin
				mul_a         = v_q;
				mul_b         = p_q;
				div_req.num   = {(v_q[31] ? 32'(-v_q) : 32'(v_q)), 16'd0};
				div_req.den   = p_q[31] ? 32'(-p_q) : 32'(p_q);
				div_req.start = (mode_eff == pba_pkg::MODE_DIV) && (p_q != 32'sd0);
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------ registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pba_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pba_pkg::S_DONE && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pba_pkg::S_IDLE: begin
				cx_q   <= coord_x;
				cy_q   <= coord_y;
				cz_q   <= coord_z;
				v_q    <= voxel_value;
				axis_q <= pba_pkg::AXIS_X;
				sat_q  <= 1'b0;
				div0_q <= 1'b0;
			end
			pba_pkg::S_NORM_GO: neg_q <= crd_off[SW];
			pba_pkg::S_NORM_WAIT: begin
				if (div_rsp.done) begin
					case (axis_q)
						pba_pkg::AXIS_X: nx_q <= norm_val;
						pba_pkg::AXIS_Y: ny_q <= norm_val;
						default:         nz_q <= norm_val;
					endcase
					axis_q <= axis_q + 2'd1;
					a_q    <= 2'd0;
					b_q    <= 2'd0;
					c_q    <= 2'd0;
					pos_q  <= '0;
					acc_q  <= '0;
				end
			end
			pba_pkg::S_TERM_INIT: begin
				m_q  <= pba_pkg::Q_ONE;
				ex_q <= a_q;
				ey_q <= b_q;
				ez_q <= c_q;
			end
			pba_pkg::S_FACT_GO: begin
				if (fact_x)      ex_q <= ex_q - 2'd1;
				else if (fact_y) ey_q <= ey_q - 2'd1;
				else if (fact_z) ez_q <= ez_q - 2'd1;
			end
			pba_pkg::S_FACT_WAIT: begin
				m_q   <= m_sat.val;
				sat_q <= sat_q | m_sat.sat;
			end
			pba_pkg::S_COEF_WAIT: begin
				acc_q <= acc_q + AW'(prod_q >>> 16);
				pos_q <= pos_q + 1'b1;
				// advance the exponent triple
				if (sum_c <= 4'(deg_max_q)) begin
					c_q <= c_q + 2'd1;
				end else if (sum_b <= 4'(deg_max_q)) begin
					c_q <= 2'd0;
					b_q <= b_q + 2'd1;
				end else begin
					c_q <= 2'd0;
					b_q <= 2'd0;
					a_q <= a_q + 2'd1;
				end
			end
			pba_pkg::S_APPLY: begin
				p_q   <= p_sat.val;
				sat_q <= sat_q | p_sat.sat;
			end
			pba_pkg::S_COMB: begin
				neg_q <= v_q[31] ^ p_q[31];
				case (mode_eff)
					pba_pkg::MODE_SUB, pba_pkg::MODE_ADD: begin
						res_q <= as_sat.val;
						sat_q <= sat_q | as_sat.sat;
					end
					pba_pkg::MODE_DIV: begin
						res_q  <= 32'sd0;
						div0_q <= (p_q == 32'sd0);
					end
					default: res_q <= p_q;
				endcase
			end
			pba_pkg::S_MULT_WAIT: begin
				res_q <= mul_sat.val;
				sat_q <= sat_q | mul_sat.sat;
			end
			pba_pkg::S_DIV_WAIT: begin
				if (div_rsp.done) begin
					res_q <= div_sat.val;
					sat_q <= sat_q | div_sat.sat;
				end
			end
			pba_pkg::S_DONE: begin
				if (out_free) begin
					out_val_q  <= res_q;
					out_stat_q <= div0_q ? pba_pkg::STATUS_DIV0 :
						(sat_q ? pba_pkg::STATUS_SAT : pba_pkg::STATUS_OK);
				end
			end
			default: ;
		endcase
	end

endmodule
